/* design/swm_pkg.sv */
// Shared constants and control types for the sliding window median filter.
// No dependencies; every other file of the block imports this package.
package swm_pkg;

	// Width of the window size register and its value after reset.
	localparam int WS_W = 5;
	localparam logic [WS_W-1:0] WS_RESET = 5'd5;

	// Defaults for the top level parameters.
	localparam int MAX_WINDOW_DEF = 16;
	localparam int SAMPLE_WIDTH_DEF = 24;

	// Control from the sequencer to the cell row and the output stage.
	typedef struct packed {
		logic load;   // an item is accepted and enters the row
		logic step;   // one compare and shift step of the row
		logic finish; // the result is moved into the output register
		logic bypass; // the item in flight skips the median
	} swm_ctrl_t;

endpackage

/* design/swm_ifs.sv */
// Valid/ready channel interfaces for samples in and results out.
// Depends on swm_pkg for the default sample width.
interface swm_sample_if
	import swm_pkg::*;
	#(parameter int W = SAMPLE_WIDTH_DEF) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swm_result_if
	import swm_pkg::*;
	#(parameter int W = SAMPLE_WIDTH_DEF) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] filtered;
	logic passed_through;
	modport source (output valid, output filtered, output passed_through, input ready);
	modport sink (input valid, input filtered, input passed_through, output ready);
endinterface

/* design/swm_cell.sv */
// One cell of the median row: holds one ring slot and ranks it against a circulating token.
// Depends on swm_pkg for the control struct and the window size width.
module swm_cell
	import swm_pkg::*;
	#(
	parameter int MAXW = MAX_WINDOW_DEF,
	parameter int SW = SAMPLE_WIDTH_DEF,
	parameter int IDX = 0
	) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  swm_ctrl_t                ctrl,
	input  logic [$clog2(MAXW)-1:0]  wr_slot,
	input  logic signed [SW-1:0]     sample,
	input  logic [WS_W-1:0]          win_size,
	input  logic signed [SW-1:0]     tok_val_in,
	input  logic [$clog2(MAXW)-1:0]  tok_slot_in,
	output logic signed [SW-1:0]     tok_val,
	output logic [$clog2(MAXW)-1:0]  tok_slot,
	output logic signed [SW-1:0]     value,
	output logic [$clog2(MAXW)-1:0]  rank
	);

	localparam int IW = $clog2(MAXW);
	localparam int CW = ((IW > WS_W) ? IW : WS_W) + 1;
	localparam logic [IW-1:0] MY_SLOT = IW'(IDX);

	logic signed [SW-1:0] value_q;
	logic signed [SW-1:0] tok_val_q;
	logic [IW-1:0] tok_slot_q;
	logic [IW-1:0] rank_q;
	logic wr_en;
	logic tok_below;

	assign wr_en = ctrl.load && (wr_slot == MY_SLOT);

	// The token counts when its slot lies in the window and it sorts below this
	// cell; equal values are ordered by slot so that ranks are all distinct.
	assign tok_below = (CW'(tok_slot_q) < CW'(win_size)) &&
		((tok_val_q < value_q) || ((tok_val_q == value_q) && (tok_slot_q < MY_SLOT)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (wr_en) begin
			value_q <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			tok_val_q <= wr_en ? sample : value_q;
			tok_slot_q <= MY_SLOT;
			rank_q <= '0;
		end else if (ctrl.step) begin
			tok_val_q <= tok_val_in;
			tok_slot_q <= tok_slot_in;
			if (tok_below) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	assign tok_val = tok_val_q;
	assign tok_slot = tok_slot_q;
	assign value = value_q;
	assign rank = rank_q;

endmodule

/* design/swm_ctrl.sv */
// Sequencer of the median filter: window size register, ring pointer and step counter.
// Depends on swm_pkg for the control struct and the register constants.
module swm_ctrl
	import swm_pkg::*;
	#(
	parameter int MAXW = MAX_WINDOW_DEF
	) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [WS_W-1:0]          cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     out_free,
	output logic [WS_W-1:0]          win_size,
	output logic [$clog2(MAXW)-1:0]  wr_slot,
	output swm_ctrl_t                ctrl
	);

	localparam int IW = $clog2(MAXW);
	localparam int CW = ((IW > WS_W) ? IW : WS_W) + 1;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [IW-1:0] LAST_STEP = IW'(MAXW - 1);

	logic [1:0] state_q;
	logic [IW-1:0] step_q;
	logic [IW-1:0] ptr_q;
	logic [WS_W-1:0] ws_q;
	logic bypass_q;
	logic accept;
	logic ws_ok;
	logic [CW-1:0] slot_next;

	assign ws_ok = (ws_q != '0) && ws_q[0] && (CW'(ws_q) <= CW'(MAXW));
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// A pointer outside the window falls back to slot zero.
	assign wr_slot = (CW'(ptr_q) >= CW'(ws_q)) ? '0 : ptr_q;
	assign slot_next = CW'(wr_slot) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			ptr_q <= '0;
			ws_q <= WS_RESET;
			bypass_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
				ptr_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						bypass_q <= !ws_ok;
						if (ws_ok) begin
							state_q <= ST_RUN;
							ptr_q <= (slot_next >= CW'(ws_q)) ? '0 : slot_next[IW-1:0];
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign win_size = ws_q;
	assign ctrl.load = accept && ws_ok;
	assign ctrl.step = (state_q == ST_RUN);
	assign ctrl.finish = (state_q == ST_DONE) && out_free;
	assign ctrl.bypass = bypass_q;

endmodule

/* design/sliding_window_median.sv */
// Sliding window median: an item is accepted only in the idle state, after the previous item has left the done state.
// A median item is ranked in the run state; a bypassed item (window size zero, even or above MAX_WINDOW) skips it.
// The run state is the rank loop: a token per cell circulates once around the row of MAX_WINDOW cells.
// Reset (arst_n low, asynchronous) clears the ring to zeros, the pointer to zero and sets the window size to 5.
// Depends on swm_pkg, swm_ifs, swm_cell and swm_ctrl.
module sliding_window_median
	import swm_pkg::*;
	#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
	) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [WS_W-1:0] cfg_wdata,
	swm_sample_if.sink      samples,
	swm_result_if.source    results
	);

	localparam int IW = $clog2(MAX_WINDOW);
	localparam int CW = ((IW > WS_W) ? IW : WS_W) + 1;

	// The ring lives in a row of cells, one slot per cell. When an item is accepted
	// the sample is written into its slot, and every cell copies its value into a
	// token. For MAX_WINDOW steps each cell compares the token in front of it with
	// its own value and then hands the token to its right neighbor, so every cell
	// sees every slot once and ends with the count of window slots that sort below
	// it. The cell whose count is half the window size holds the median.

	swm_ctrl_t ctrl;
	logic [WS_W-1:0] win_size;
	logic [IW-1:0] wr_slot;
	logic out_free;

	logic signed [SAMPLE_WIDTH-1:0] tok_val [MAX_WINDOW];
	logic [IW-1:0] tok_slot [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
	logic [IW-1:0] cell_rank [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] hit;
	logic signed [SAMPLE_WIDTH-1:0] median;

	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] filtered_q;
	logic passed_q;
	logic out_valid_q;

	// The output register frees up as soon as its item is taken, so the next
	// result can be loaded in the same cycle.
	assign out_free = !out_valid_q || results.ready;

	swm_ctrl #(
		.MAXW(MAX_WINDOW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.out_free(out_free),
		.win_size(win_size),
		.wr_slot(wr_slot),
		.ctrl(ctrl)
	);

	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
		localparam int PREV = (g == 0) ? MAX_WINDOW - 1 : g - 1;
		localparam logic [CW-1:0] SLOT_C = CW'(g);

		swm_cell #(
			.MAXW(MAX_WINDOW),
			.SW(SAMPLE_WIDTH),
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.wr_slot(wr_slot),
			.sample(samples.sample),
			.win_size(win_size),
			.tok_val_in(tok_val[PREV]),
			.tok_slot_in(tok_slot[PREV]),
			.tok_val(tok_val[g]),
			.tok_slot(tok_slot[g]),
			.value(cell_value[g]),
			.rank(cell_rank[g])
		);

		// Only a slot inside the window can be the median.
		assign hit[g] = (SLOT_C < CW'(win_size)) &&
			(CW'(cell_rank[g]) == CW'(win_size >> 1));
	end

	// Ranks are distinct, so at most one cell hits and an OR of the masked values selects it.
	always_comb begin
		median = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (hit[i]) begin
				median = median | cell_value[i];
			end
		end
	end

	// The accepted sample is kept for the bypass case.
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_q <= samples.sample;
		end
		if (ctrl.finish) begin
			filtered_q <= ctrl.bypass ? sample_q : median;
			passed_q <= ctrl.bypass;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid = out_valid_q;
	assign results.filtered = filtered_q;
	assign results.passed_through = passed_q;

`ifndef SYNTHESIS
	// A result shows up only when the sequencer hands one over.
	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.finish))
		else $error("result became valid without a finish step");

	// No new item enters while the row is still ranking.
	a_no_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step |-> !samples.ready)
		else $error("input ready while ranking");

	// A median item finds exactly one cell at the middle rank.
	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.finish && !ctrl.bypass) |-> $onehot(hit))
		else $error("median select is not one-hot");

	// The write slot of a median item lies inside the window.
	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> (CW'(wr_slot) < CW'(win_size)))
		else $error("write slot outside the window");
`endif

endmodule
